### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define CCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// cons must hold in the cycle after ante
`define CCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CCA_ASSERT(lbl, prop)
`define CCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/cca_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock advance package
// Item types, control and status bundles and constants shared by the block.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam int MAX_MONTHS    = 12;
	localparam int MONTH_LEN_W   = 5;
	localparam int MIN_PER_HOUR  = 60;
	localparam int HOUR_PER_DAY  = 24;
	// reciprocals scaled by 2^RECIP_SHIFT, exact over the operand ranges used
	localparam int RECIP_60      = 1093;
	localparam int RECIP_24      = 2731;
	localparam int RECIP_SHIFT   = 16;
	localparam int MON_ROLL_MAX  = 1023;
	localparam int YR_ROLL_MAX   = 127;

	localparam int CFG_ADDR_W    = 1;
	localparam int CFG_DATA_W    = 60;
	localparam logic [CFG_ADDR_W-1:0] REG_MONTH_COUNT   = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MONTH_LENGTHS = 1'd1;

	localparam logic [3:0]            MONTH_COUNT_RST   = 4'd12;
	localparam logic [CFG_DATA_W-1:0] MONTH_LENGTHS_RST = 60'd1151794505154789279;

	typedef struct packed {
		logic [9:0] add_days;
		logic [7:0] add_hours;
		logic [9:0] add_minutes;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  minute_now;
		logic [4:0]  hour_now;
		logic [4:0]  day_now;
		logic [3:0]  month_now;
		logic [15:0] year_now;
		logic [5:0]  hours_rolled;
		logic [9:0]  days_rolled;
		logic [9:0]  months_rolled;
		logic [6:0]  years_rolled;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic mul_min;
		logic fix_min;
		logic mul_hour;
		logic fix_hour;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic out_free;
	} status_t;

endpackage

### hdl/cca_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar clock advance controller
// Sequences one item: minute carry, hour carry, month walk, result hand-off.
// ----------------------------------------------------------------------------
module cca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cca_pkg::status_t status,
	output cca_pkg::cmd_t    cmd
);
	import cca_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MMUL = 7'b0000010,
		S_MFIX = 7'b0000100,
		S_HMUL = 7'b0001000,
		S_HFIX = 7'b0010000,
		S_LOOP = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MMUL;
				end
			end
			S_MMUL: begin
				cmd.mul_min = 1'b1;
				state_d     = S_MFIX;
			end
			S_MFIX: begin
				cmd.fix_min = 1'b1;
				state_d     = S_HMUL;
			end
			S_HMUL: begin
				cmd.mul_hour = 1'b1;
				state_d      = S_HFIX;
			end
			S_HFIX: begin
				cmd.fix_hour = 1'b1;
				state_d      = S_LOOP;
			end
			S_LOOP: begin
				if (status.more) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### hdl/cca_dp.sv
// ----------------------------------------------------------------------------
// Calendar clock advance datapath
// Time and date state, configuration, reciprocal multiplier and result register.
// ----------------------------------------------------------------------------
module cca_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cca_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cca_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [cca_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [cca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  cca_pkg::cmd_t                      cmd,
	output cca_pkg::status_t                   status
);
	import cca_pkg::*;

	logic [3:0]            month_count_q;
	logic [CFG_DATA_W-1:0] month_lengths_q;

	logic [5:0]  minute_q;
	logic [4:0]  hour_q;
	logic [10:0] day_q;
	logic [3:0]  month_q;
	logic [15:0] year_q;

	logic [9:0]  add_days_q;
	logic [7:0]  add_hours_q;
	logic [10:0] m_q;
	logic [8:0]  h_q;
	logic [20:0] prod_q;
	logic [4:0]  hr_roll_q;
	logic [3:0]  day_roll_q;
	logic [9:0]  mon_roll_q;
	logic [6:0]  yr_roll_q;

	out_item_t   out_q;
	logic        out_valid_q;

	logic [10:0] mul_a;
	logic [11:0] mul_b;
	logic [22:0] mul_p;
	logic [4:0]  q_min;
	logic [3:0]  q_hr;
	logic [10:0] min_rem;
	logic [8:0]  hr_rem;

	logic [MONTH_LEN_W-1:0] len_tab [MAX_MONTHS];
	logic [MONTH_LEN_W-1:0] raw_len;
	logic [MONTH_LEN_W-1:0] cur_len;
	logic [3:0]             act_cnt;
	logic [3:0]             month_inc;
	logic                   year_wrap;

	for (genvar i = 0; i < MAX_MONTHS; i++) begin : g_len
		assign len_tab[i] = month_lengths_q[i*MONTH_LEN_W +: MONTH_LEN_W];
	end

	always_comb begin
		raw_len = (month_q < 4'(MAX_MONTHS)) ? len_tab[month_q] : MONTH_LEN_W'(1);
		cur_len = (raw_len == '0) ? MONTH_LEN_W'(1) : raw_len;
	end

	always_comb begin
		priority if (month_count_q == 4'd0) begin
			act_cnt = 4'd1;
		end else if (month_count_q > 4'(MAX_MONTHS)) begin
			act_cnt = 4'(MAX_MONTHS);
		end else begin
			act_cnt = month_count_q;
		end
	end

	assign month_inc = month_q + 4'd1;
	assign year_wrap = (month_inc >= act_cnt);

	assign mul_a   = cmd.mul_hour ? 11'(h_q) : m_q;
	assign mul_b   = cmd.mul_hour ? 12'(RECIP_24) : 12'(RECIP_60);
	assign mul_p   = 23'(mul_a) * 23'(mul_b);
	assign q_min   = prod_q[RECIP_SHIFT +: 5];
	assign q_hr    = prod_q[RECIP_SHIFT +: 4];
	assign min_rem = m_q - 11'(q_min) * 11'(MIN_PER_HOUR);
	assign hr_rem  = h_q - 9'(q_hr) * 9'(HOUR_PER_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_count_q   <= MONTH_COUNT_RST;
			month_lengths_q <= MONTH_LENGTHS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MONTH_COUNT:   month_count_q   <= cfg_wdata[3:0];
				REG_MONTH_LENGTHS: month_lengths_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_q <= 6'd0;
			hour_q   <= 5'd12;
			day_q    <= 11'd1;
			month_q  <= 4'd0;
			year_q   <= 16'd0;
		end else begin
			if (cmd.fix_min) begin
				minute_q <= min_rem[5:0];
			end
			if (cmd.fix_hour) begin
				hour_q <= hr_rem[4:0];
				day_q  <= day_q + 11'(add_days_q) + 11'(q_hr);
			end
			if (cmd.step) begin
				day_q <= day_q - 11'(cur_len);
				if (year_wrap) begin
					month_q <= 4'd0;
					year_q  <= year_q + 16'd1;
				end else begin
					month_q <= month_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			add_days_q  <= in_data.add_days;
			add_hours_q <= in_data.add_hours;
			m_q         <= 11'(minute_q) + 11'(in_data.add_minutes);
			mon_roll_q  <= '0;
			yr_roll_q   <= '0;
		end
		if (cmd.mul_min || cmd.mul_hour) begin
			prod_q <= mul_p[20:0];
		end
		if (cmd.fix_min) begin
			hr_roll_q <= q_min;
			h_q       <= 9'(hour_q) + 9'(add_hours_q) + 9'(q_min);
		end
		if (cmd.fix_hour) begin
			day_roll_q <= q_hr;
		end
		if (cmd.step) begin
			if (mon_roll_q != 10'(MON_ROLL_MAX)) begin
				mon_roll_q <= mon_roll_q + 10'd1;
			end
			if (year_wrap && (yr_roll_q != 7'(YR_ROLL_MAX))) begin
				yr_roll_q <= yr_roll_q + 7'd1;
			end
		end
		if (cmd.emit) begin
			out_q.minute_now    <= minute_q;
			out_q.hour_now      <= hour_q;
			out_q.day_now       <= day_q[4:0];
			out_q.month_now     <= month_q;
			out_q.year_now      <= year_q;
			out_q.hours_rolled  <= 6'(hr_roll_q);
			out_q.days_rolled   <= 10'(day_roll_q);
			out_q.months_rolled <= mon_roll_q;
			out_q.years_rolled  <= yr_roll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.more     = (day_q > 11'(cur_len));
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/calendar_clock_advance_top.sv
// ----------------------------------------------------------------------------
// Calendar clock advance
// Adds days, hours and minutes to a calendar clock and normalises the date.
// ----------------------------------------------------------------------------
// One item at a time: the next item is taken only once this one's result is
// loaded. The block takes the item, does the minute reciprocal multiply and
// its correction, then the hour reciprocal multiply and its correction, then
// walks the months, subtracting one month length a cycle, once for each month
// advance the item causes, finds the walk done and loads the result into the
// output register. A result still waiting holds the item after it at its
// hand-off.
// Configuration is written on cfg_we with cfg_addr 0 for the month count and
// 1 for the packed month lengths.
`include "assert_macros.svh"

module calendar_clock_advance_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cca_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cca_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [cca_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [cca_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cca_pkg::*;

	cmd_t    cmd;
	status_t status;

	cca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

	`CCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`CCA_ASSERT(a_emit_free, !cmd.emit || !out_valid || !out_stall)
	`CCA_ASSERT(a_cmd_excl, $onehot0(cmd))

endmodule

### test/tb_calendar_clock_advance_top.sv
// ----------------------------------------------------------------------------
// Calendar clock advance testbench
// Drives day/hour/minute advances into the block over a range of month tables
// and month counts, predicts each resulting date and rollover count, and checks
// every result item against the prediction in order of arrival.
// ----------------------------------------------------------------------------
module tb_calendar_clock_advance_top;

	import cca_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 300;
	localparam logic [CFG_DATA_W-1:0] ALL_LONG = {CFG_DATA_W{1'b1}};

	class calendar_tracker;
		logic [3:0]            month_count;
		logic [CFG_DATA_W-1:0] month_lengths;
		logic [5:0]            minute_st;
		logic [4:0]            hour_st;
		logic [10:0]           day_st;
		logic [3:0]            month_st;
		logic [15:0]           year_st;
		out_item_t             due_dates[$];
		int                    errors;

		function new();
			month_count   = MONTH_COUNT_RST;
			month_lengths = MONTH_LENGTHS_RST;
			minute_st     = 6'd0;
			hour_st       = 5'd12;
			day_st        = 11'd1;
			month_st      = 4'd0;
			year_st       = 16'd0;
			errors        = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_MONTH_COUNT)
				month_count = val[3:0];
			else if (idx == REG_MONTH_LENGTHS)
				month_lengths = val;
		endfunction

		function int unsigned days_in(logic [3:0] idx);
			int unsigned len;
			if (idx >= MAX_MONTHS)
				return 1;
			len = 32'(month_lengths[idx*MONTH_LEN_W +: MONTH_LEN_W]);
			return (len == 0) ? 1 : len;
		endfunction

		function void note_advance(in_item_t it);
			int unsigned m, h, d, len, cnt;
			int unsigned hr_roll, day_roll, mon_roll, yr_roll;
			out_item_t   e;
			cnt = 32'(month_count);
			if (cnt == 0)
				cnt = 1;
			if (cnt > MAX_MONTHS)
				cnt = MAX_MONTHS;
			mon_roll = 0;
			yr_roll  = 0;
			m = minute_st + it.add_minutes;
			hr_roll = m / MIN_PER_HOUR;
			m = m % MIN_PER_HOUR;
			h = hour_st + it.add_hours + hr_roll;
			day_roll = h / HOUR_PER_DAY;
			h = h % HOUR_PER_DAY;
			d = day_st + it.add_days + day_roll;
			len = days_in(month_st);
			while (d > len) begin
				d -= len;
				month_st = month_st + 4'd1;
				if (mon_roll < MON_ROLL_MAX)
					mon_roll++;
				if (month_st >= cnt) begin
					month_st = 4'd0;
					year_st  = year_st + 16'd1;
					if (yr_roll < YR_ROLL_MAX)
						yr_roll++;
				end
				len = days_in(month_st);
			end
			minute_st = 6'(m);
			hour_st   = 5'(h);
			day_st    = 11'(d);
			e.minute_now    = minute_st;
			e.hour_now      = hour_st;
			e.day_now       = day_st[4:0];
			e.month_now     = month_st;
			e.year_now      = year_st;
			e.hours_rolled  = 6'(hr_roll);
			e.days_rolled   = 10'(day_roll);
			e.months_rolled = 10'(mon_roll);
			e.years_rolled  = 7'(yr_roll);
			due_dates.push_back(e);
		endfunction

		function void cmp(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_date(out_item_t got);
			out_item_t e;
			if (due_dates.size() == 0) begin
				$error("result item with no advance outstanding");
				errors++;
				return;
			end
			e = due_dates.pop_front();
			cmp("minute_now", e.minute_now, got.minute_now);
			cmp("hour_now", e.hour_now, got.hour_now);
			cmp("day_now", e.day_now, got.day_now);
			cmp("month_now", e.month_now, got.month_now);
			cmp("year_now", e.year_now, got.year_now);
			cmp("hours_rolled", e.hours_rolled, got.hours_rolled);
			cmp("days_rolled", e.days_rolled, got.days_rolled);
			cmp("months_rolled", e.months_rolled, got.months_rolled);
			cmp("years_rolled", e.years_rolled, got.years_rolled);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	calendar_tracker book = new();
	int              results_seen = 0;
	int              quiet_cycles = 0;

	calendar_clock_advance_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				book.check_date(out_data);
				results_seen++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_calendar_clock_advance_top NOT OK");
					$finish;
				end
			end
		end
	end

	// receiver: stall pattern in stretches, with one long hold-off
	initial begin
		int  mode;
		int  stretch;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(5, 80);
			for (int i = 0; i < stretch; i++) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= i[0];
				endcase
			end
		end
	end

	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		book.note_advance(it);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_one(logic [9:0] d, logic [7:0] h, logic [9:0] m);
		in_item_t it;
		it.add_days    = d;
		it.add_hours   = h;
		it.add_minutes = m;
		send_item(it);
		stop_sending();
	endtask

	task automatic wait_idle();
		while (book.due_dates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		book.set_reg(idx, val);
	endtask

	task automatic set_calendar(logic [3:0] count, logic [CFG_DATA_W-1:0] lengths);
		wait_idle();
		write_reg(REG_MONTH_COUNT, {{(CFG_DATA_W-4){1'b0}}, count});
		write_reg(REG_MONTH_LENGTHS, lengths);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_lengths();
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		for (int i = 0; i < MAX_MONTHS; i++)
			v[i*MONTH_LEN_W +: MONTH_LEN_W] = ($urandom_range(0, 5) == 0) ?
				MONTH_LEN_W'(0) : MONTH_LEN_W'($urandom_range(0, 31));
		return v;
	endfunction

	// long_days: push whole years through a one-day calendar
	function automatic in_item_t random_advance(bit long_days);
		in_item_t it;
		if (long_days)
			it.add_days = 10'($urandom_range(900, 1023));
		else if ($urandom_range(0, 7) == 0)
			it.add_days = 10'($urandom_range(0, 1023));
		else
			it.add_days = 10'($urandom_range(0, 60));
		it.add_hours   = 8'($urandom_range(0, 255));
		it.add_minutes = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	task automatic send_bursts(int n, bit long_days);
		int burst;
		int gap;
		while (n > 0) begin
			burst = $urandom_range(1, 30);
			if (burst > n)
				burst = n;
			for (int i = 0; i < burst; i++)
				send_item(random_advance(long_days));
			n -= burst;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0 || n == 0) begin
				stop_sending();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes on the default calendar
		set_calendar(MONTH_COUNT_RST, MONTH_LENGTHS_RST);
		send_one(10'd0, 8'd0, 10'd0);
		send_one(10'd0, 8'd0, 10'd59);
		send_one(10'd0, 8'd0, 10'd1);
		send_one(10'd1023, 8'd255, 10'd1023);
		send_one(10'd0, 8'd0, 10'd1023);
		send_one(10'd0, 8'd255, 10'd0);
		send_one(10'd1023, 8'd0, 10'd0);

		// one-month year of one-day months: both rollover counts saturate
		set_calendar(4'd1, '0);
		send_one(10'd1023, 8'd255, 10'd1023);
		send_one(10'd1023, 8'd0, 10'd0);

		// month left beyond a lowered month count
		set_calendar(4'd12, MONTH_LENGTHS_RST);
		while (book.month_st < 5)
			send_one(10'd25, 8'd0, 10'd0);
		set_calendar(4'd3, MONTH_LENGTHS_RST);
		send_one(10'd0, 8'd0, 10'd0);
		send_one(10'd40, 8'd0, 10'd0);

		// month count zero and above the maximum
		set_calendar(4'd0, random_lengths());
		send_one(10'd100, 8'd30, 10'd200);
		set_calendar(4'd13, random_lengths());
		send_one(10'd400, 8'd30, 10'd200);

		// random phases
		set_calendar(MONTH_COUNT_RST, MONTH_LENGTHS_RST);
		send_bursts(250, 1'b0);
		set_calendar(4'd1, '0);
		send_bursts(70, 1'b1);
		send_bursts(100, 1'b0);
		set_calendar(4'd15, ALL_LONG);
		send_bursts(200, 1'b0);
		set_calendar(4'd0, random_lengths());
		send_bursts(150, 1'b0);
		repeat (6) begin
			set_calendar(4'($urandom_range(0, 15)), random_lengths());
			send_bursts(150, 1'b0);
		end
		set_calendar(4'd12, '0);
		send_bursts(40, 1'b0);

		while (book.due_dates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.due_dates.size() == 0)
			$display("tb_calendar_clock_advance_top OK");
		else
			$display("tb_calendar_clock_advance_top NOT OK");
		$finish;
	end

endmodule
